>>> src/socks5_request_parser_unit_macros.svh
// Assertion helpers shared by the parser checks.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef SOCKS5_REQUEST_PARSER_UNIT_MACROS_SVH
`define SOCKS5_REQUEST_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/srp_pkg.sv
`timescale 1ns / 1ps

package srp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] status_t;
    typedef logic [15:0] port_t;

    // Result status codes
    localparam status_t ST_BUSY     = 3'd0;
    localparam status_t ST_DONE     = 3'd1;
    localparam status_t ST_BAD_VER  = 3'd2;
    localparam status_t ST_BAD_CMD  = 3'd3;
    localparam status_t ST_BAD_ATYP = 3'd4;
    localparam status_t ST_AFTER    = 3'd5;

    // Protocol constants
    localparam byte_t SOCKS_VERSION = 8'h05;
    localparam byte_t CMD_TCP_OUT   = 8'h01;
    localparam byte_t CMD_TCP_IN    = 8'h02;
    localparam byte_t CMD_UDP_ASSOC = 8'h03;
    localparam byte_t ATYP_IPV4     = 8'h01;
    localparam byte_t ATYP_DOMAIN   = 8'h03;
    localparam byte_t ATYP_IPV6     = 8'h04;
    localparam byte_t LEN_IPV4      = 8'd4;
    localparam byte_t LEN_IPV6      = 8'd16;

endpackage

>>> src/srp_if.sv
`timescale 1ns / 1ps

interface srp_req_if;
    import srp_pkg::*;

    logic  valid;
    logic  ready;
    logic  restart;
    byte_t data_byte;

    modport source (output valid, output restart, output data_byte, input ready);
    modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface srp_res_if;
    import srp_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    logic    addr_valid;
    byte_t   addr_byte;
    byte_t   addr_index;
    byte_t   command;
    byte_t   address_type;
    byte_t   address_length;
    port_t   dest_port;

    modport source (
        output valid, output status, output addr_valid, output addr_byte,
        output addr_index, output command, output address_type,
        output address_length, output dest_port, input ready
    );
    modport sink (
        input valid, input status, input addr_valid, input addr_byte,
        input addr_index, input command, input address_type,
        input address_length, input dest_port, output ready
    );
endinterface

>>> src/socks5_request_parser_unit.sv
`timescale 1ns / 1ps
// SOCKS5 request parser: one request byte in, one result word out.
// req carries restart and data_byte; restart=1 makes this byte the version
// byte of a fresh request. res carries, for every input word, the status
// (in progress, complete or an error code), the address byte with its index
// when the byte belongs to the address, and the captured command, address
// type, address length and destination port.
// Path: a word accepted on req passes the input register, then the result
// register, before it shows on res. Throughput: one byte per cycle while
// res is taken, set by the phase update between the two registers.
// Errors are sticky: once an error is reported, every later byte reports
// the same code until a word with restart=1 arrives.
// Reset: the parser expects a version byte, all captured fields read zero,
// and both pipeline registers are empty.
// Stall: when res is not taken, the result register holds; the input
// register holds behind it, and req.ready drops only once both are full.
module socks5_request_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    srp_req_if.sink   req,
    srp_res_if.source res
);
    import srp_pkg::*;

    localparam logic [3:0] PH_VER     = 4'd0;
    localparam logic [3:0] PH_CMD     = 4'd1;
    localparam logic [3:0] PH_RSV     = 4'd2;
    localparam logic [3:0] PH_ATYP    = 4'd3;
    localparam logic [3:0] PH_ADDR    = 4'd4;
    localparam logic [3:0] PH_DOMLEN  = 4'd5;
    localparam logic [3:0] PH_PORT_HI = 4'd6;
    localparam logic [3:0] PH_PORT_LO = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;
    localparam logic [3:0] PH_ERROR   = 4'd9;

    // Input register
    logic    in_valid_reg;
    logic    in_restart_reg;
    byte_t   in_byte_reg;

    // Parser state
    logic [3:0] phase_reg, phase_next;
    byte_t   cmd_reg, cmd_next;
    byte_t   atyp_reg, atyp_next;
    byte_t   len_reg, len_next;
    byte_t   count_reg, count_next;
    port_t   port_reg, port_next;
    status_t err_reg, err_next;

    // Result register
    logic    out_valid_reg;
    status_t status_reg, status_next;
    logic    av_reg, av_next;
    byte_t   ab_reg, ab_next;
    byte_t   ai_reg, ai_next;

    // Restart-adjusted view of the state
    logic [3:0] cur_phase;
    byte_t   cur_cmd, cur_atyp, cur_len, cur_count;
    port_t   cur_port;
    status_t cur_err;
    byte_t   count_inc;

    logic    out_open;
    logic    step;

    // Advance the result stage when it is empty or being drained.
    assign out_open  = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && out_open;
    assign req.ready = !in_valid_reg || out_open;

    always_comb
    begin
        if (in_restart_reg)
        begin
            cur_phase = PH_VER;
            cur_cmd   = '0;
            cur_atyp  = '0;
            cur_len   = '0;
            cur_count = '0;
            cur_port  = '0;
            cur_err   = ST_BUSY;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_cmd   = cmd_reg;
            cur_atyp  = atyp_reg;
            cur_len   = len_reg;
            cur_count = count_reg;
            cur_port  = port_reg;
            cur_err   = err_reg;
        end
        count_inc = cur_count + 8'd1;

        phase_next  = cur_phase;
        cmd_next    = cur_cmd;
        atyp_next   = cur_atyp;
        len_next    = cur_len;
        count_next  = cur_count;
        port_next   = cur_port;
        err_next    = cur_err;
        status_next = ST_BUSY;
        av_next     = 1'b0;
        ab_next     = '0;
        ai_next     = '0;

        case (cur_phase)
            PH_VER:
            begin
                if (in_byte_reg != SOCKS_VERSION)
                begin
                    status_next = ST_BAD_VER;
                    err_next    = ST_BAD_VER;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD:
            begin
                // Capture the command even when it is rejected.
                cmd_next = in_byte_reg;
                if (in_byte_reg inside {CMD_TCP_OUT, CMD_TCP_IN, CMD_UDP_ASSOC})
                begin
                    phase_next = PH_RSV;
                end
                else
                begin
                    status_next = ST_BAD_CMD;
                    err_next    = ST_BAD_CMD;
                    phase_next  = PH_ERROR;
                end
            end
            PH_RSV:
            begin
                phase_next = PH_ATYP;
            end
            PH_ATYP:
            begin
                atyp_next  = in_byte_reg;
                count_next = '0;
                case (in_byte_reg)
                    ATYP_IPV4:
                    begin
                        len_next   = LEN_IPV4;
                        phase_next = PH_ADDR;
                    end
                    ATYP_IPV6:
                    begin
                        len_next   = LEN_IPV6;
                        phase_next = PH_ADDR;
                    end
                    ATYP_DOMAIN:
                    begin
                        phase_next = PH_DOMLEN;
                    end
                    default:
                    begin
                        status_next = ST_BAD_ATYP;
                        err_next    = ST_BAD_ATYP;
                        phase_next  = PH_ERROR;
                    end
                endcase
            end
            PH_DOMLEN:
            begin
                len_next   = in_byte_reg;
                count_next = '0;
                // An empty domain name goes straight to the port.
                phase_next = (in_byte_reg == 8'd0) ? PH_PORT_HI : PH_ADDR;
            end
            PH_ADDR:
            begin
                av_next    = 1'b1;
                ab_next    = in_byte_reg;
                ai_next    = cur_count;
                count_next = count_inc;
                if (count_inc >= cur_len)
                begin
                    phase_next = PH_PORT_HI;
                end
            end
            PH_PORT_HI:
            begin
                port_next  = {in_byte_reg, 8'd0};
                phase_next = PH_PORT_LO;
            end
            PH_PORT_LO:
            begin
                port_next   = {cur_port[15:8], cur_port[7:0] | in_byte_reg};
                phase_next  = PH_DONE;
                status_next = ST_DONE;
            end
            PH_DONE:
            begin
                status_next = ST_AFTER;
                err_next    = ST_AFTER;
                phase_next  = PH_ERROR;
            end
            default:
            begin
                // Sticky error: repeat the stored code.
                phase_next  = PH_ERROR;
                status_next = cur_err;
            end
        endcase
    end

    // Input register: load on accept, drop once handed to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_restart_reg <= req.restart;
            in_byte_reg    <= req.data_byte;
        end
    end

    // Parser state advances once per byte moved into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VER;
            cmd_reg   <= '0;
            atyp_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            port_reg  <= '0;
            err_reg   <= ST_BUSY;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            atyp_reg  <= atyp_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            port_reg  <= port_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Per-byte result fields; captured fields come from the state registers.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg <= status_next;
            av_reg     <= av_next;
            ab_reg     <= ab_next;
            ai_reg     <= ai_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = status_reg;
    assign res.addr_valid     = av_reg;
    assign res.addr_byte      = ab_reg;
    assign res.addr_index     = ai_reg;
    assign res.command        = cmd_reg;
    assign res.address_type   = atyp_reg;
    assign res.address_length = len_reg;
    assign res.dest_port      = port_reg;

endmodule

>>> src/srp_checker.sv
`timescale 1ns / 1ps
`include "socks5_request_parser_unit_macros.svh"

module srp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input srp_pkg::status_t res_status,
    input logic           res_addr_valid,
    input srp_pkg::byte_t res_addr_byte,
    input srp_pkg::byte_t res_addr_index,
    input srp_pkg::byte_t res_address_type,
    input srp_pkg::byte_t res_address_length
);
    import srp_pkg::*;

    `SRP_ASSERT_NOW(a_status_range, res_valid, res_status <= ST_AFTER, "status code out of range")

    `SRP_ASSERT_NOW(a_addr_busy, res_valid && res_addr_valid, res_status == ST_BUSY, "address byte with non-busy status")

    `SRP_ASSERT_NOW(a_addr_zero, res_valid && !res_addr_valid, res_addr_byte == 8'd0 && res_addr_index == 8'd0, "address fields not cleared")

    `SRP_ASSERT_NOW(a_addr_bound, res_valid && res_addr_valid, res_addr_index < res_address_length && (res_address_type == ATYP_IPV4 || res_address_type == ATYP_IPV6 || res_address_type == ATYP_DOMAIN), "address index or type inconsistent")

    `SRP_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_addr_index), "stalled result word changed")

endmodule

bind socks5_request_parser_unit srp_checker u_srp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_status         (res.status),
    .res_addr_valid     (res.addr_valid),
    .res_addr_byte      (res.addr_byte),
    .res_addr_index     (res.addr_index),
    .res_address_type   (res.address_type),
    .res_address_length (res.address_length)
);

>>> bench/socks5_request_parser_unit_check.sv
`timescale 1ns / 1ps

module socks5_request_parser_unit_check (
    input  logic clk,
    input  logic rst_n,
    srp_req_if   req,
    srp_res_if   res,
    output int   mismatches,
    output int   in_flight,
    output int   compared,
    output int   completed
);
    import srp_pkg::*;

    typedef enum logic [3:0] {
        PH_VERSION,
        PH_COMMAND,
        PH_RESERVED,
        PH_ADDR_TYPE,
        PH_ADDRESS,
        PH_DOMAIN_LEN,
        PH_PORT_HIGH,
        PH_PORT_LOW,
        PH_COMPLETE,
        PH_FAILED
    } parse_phase_t;

    typedef struct packed {
        status_t status;
        logic    addr_valid;
        byte_t   addr_byte;
        byte_t   addr_index;
        byte_t   command;
        byte_t   address_type;
        byte_t   address_length;
        port_t   dest_port;
    } parse_word_t;

    parse_phase_t phase;
    byte_t        cmd_q;
    byte_t        atyp_q;
    byte_t        len_q;
    byte_t        count_q;
    port_t        port_q;
    status_t      err_q;

    parse_word_t  expected_words[$];

    function automatic void clear_parser();
        phase   = PH_VERSION;
        cmd_q   = '0;
        atyp_q  = '0;
        len_q   = '0;
        count_q = '0;
        port_q  = '0;
        err_q   = ST_BUSY;
    endfunction

    function automatic status_t enter_error(input status_t code);
        err_q = code;
        phase = PH_FAILED;
        return code;
    endfunction

    // Advance the parser by one byte and return the word it should report.
    function automatic parse_word_t parse_byte(input logic rs, input byte_t b);
        parse_word_t w;
        w = '0;
        w.status = ST_BUSY;
        if (rs)
            clear_parser();
        case (phase)
            PH_VERSION:
                if (b != SOCKS_VERSION)
                    w.status = enter_error(ST_BAD_VER);
                else
                    phase = PH_COMMAND;
            PH_COMMAND:
            begin
                cmd_q = b;
                if (b != CMD_TCP_OUT && b != CMD_TCP_IN && b != CMD_UDP_ASSOC)
                    w.status = enter_error(ST_BAD_CMD);
                else
                    phase = PH_RESERVED;
            end
            PH_RESERVED:
                phase = PH_ADDR_TYPE;
            PH_ADDR_TYPE:
            begin
                atyp_q  = b;
                count_q = '0;
                if (b == ATYP_IPV4)
                begin
                    len_q = LEN_IPV4;
                    phase = PH_ADDRESS;
                end
                else if (b == ATYP_IPV6)
                begin
                    len_q = LEN_IPV6;
                    phase = PH_ADDRESS;
                end
                else if (b == ATYP_DOMAIN)
                    phase = PH_DOMAIN_LEN;
                else
                    w.status = enter_error(ST_BAD_ATYP);
            end
            PH_DOMAIN_LEN:
            begin
                len_q   = b;
                count_q = '0;
                phase   = (b == 8'd0) ? PH_PORT_HIGH : PH_ADDRESS;
            end
            PH_ADDRESS:
            begin
                w.addr_valid = 1'b1;
                w.addr_byte  = b;
                w.addr_index = count_q;
                count_q      = count_q + 8'd1;
                if (count_q >= len_q)
                    phase = PH_PORT_HIGH;
            end
            PH_PORT_HIGH:
            begin
                port_q = {b, 8'h00};
                phase  = PH_PORT_LOW;
            end
            PH_PORT_LOW:
            begin
                port_q   = port_q | {8'h00, b};
                phase    = PH_COMPLETE;
                w.status = ST_DONE;
            end
            PH_COMPLETE:
                w.status = enter_error(ST_AFTER);
            default:
                w.status = err_q;
        endcase
        w.command        = cmd_q;
        w.address_type   = atyp_q;
        w.address_length = len_q;
        w.dest_port      = port_q;
        return w;
    endfunction

    function automatic string show(input parse_word_t w);
        return $sformatf(
            "st=%0d av=%0d byte=%02h idx=%0d cmd=%02h atyp=%02h len=%0d port=%04h",
            w.status, w.addr_valid, w.addr_byte, w.addr_index, w.command,
            w.address_type, w.address_length, w.dest_port);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_word_t got;
        parse_word_t want;
        string       diffs;
        if (!rst_n)
        begin
            clear_parser();
            expected_words.delete();
            mismatches = 0;
            in_flight  = 0;
            compared   = 0;
            completed  = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_words.push_back(parse_byte(req.restart, req.data_byte));
            if (res.valid && res.ready)
            begin
                got.status         = res.status;
                got.addr_valid     = res.addr_valid;
                got.addr_byte      = res.addr_byte;
                got.addr_index     = res.addr_index;
                got.command        = res.command;
                got.address_type   = res.address_type;
                got.address_length = res.address_length;
                got.dest_port      = res.dest_port;
                if (expected_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] result word with nothing pending: %s", $realtime,
                                 show(got));
                    mismatches++;
                end
                else
                begin
                    want  = expected_words.pop_front();
                    diffs = "";
                    if (got.status !== want.status)                 diffs = {diffs, " status"};
                    if (got.addr_valid !== want.addr_valid)         diffs = {diffs, " addr_valid"};
                    if (got.addr_byte !== want.addr_byte)           diffs = {diffs, " addr_byte"};
                    if (got.addr_index !== want.addr_index)         diffs = {diffs, " addr_index"};
                    if (got.command !== want.command)               diffs = {diffs, " command"};
                    if (got.address_type !== want.address_type)
                        diffs = {diffs, " address_type"};
                    if (got.address_length !== want.address_length)
                        diffs = {diffs, " address_length"};
                    if (got.dest_port !== want.dest_port)           diffs = {diffs, " dest_port"};
                    if (diffs != "")
                    begin
                        if (mismatches < 10)
                        begin
                            $display("[%0t] mismatch in%s", $realtime, diffs);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                        mismatches++;
                    end
                    if (want.status == ST_DONE)
                        completed++;
                    compared++;
                end
            end
            in_flight = expected_words.size();
        end
    end

endmodule

>>> bench/socks5_request_parser_unit_test.sv
`timescale 1ns / 1ps

module socks5_request_parser_unit_test;
    import srp_pkg::*;

    // Random part length in request bytes, and the hard stop in clock cycles.
    // Worst case per byte is a long sender gap plus a long receiver stall
    // plus the two-stage pipeline; the limit allows for that worst case on
    // every byte of the whole run.
    localparam int RANDOM_BYTES = 1250;
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n;

    srp_req_if req_ch ();
    srp_res_if res_ch ();

    int    mismatches;
    int    in_flight;
    int    compared;
    int    completed;

    int    cycle_count = 0;
    int    bytes_sent  = 0;
    int    frames_sent = 0;
    bit    calm        = 1'b0;   // set for whole frames: no gaps, no stalls
    byte_t frame[$];             // bytes of the request being sent

    socks5_request_parser_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Watches both channels, predicts every result word and compares.
    socks5_request_parser_unit_check parse_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .mismatches (mismatches),
        .in_flight  (in_flight),
        .compared   (compared),
        .completed  (completed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still pending", cycle_count,
                     in_flight);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: hold ready low for a random stretch now and then.
    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Present one word on req after an optional gap, and hold it until taken.
    // valid stays high between back-to-back words.
    task automatic send_word(input logic rs, input byte_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.restart   <= rs;
        req_ch.data_byte <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Send the queued frame; only its first byte carries restart.
    task automatic send_frame();
        foreach (frame[i])
            send_word(i == 0, frame[i]);
        frames_sent++;
    endtask

    // Build a well-formed request with random content. Domain names are
    // mostly short; a zero length and the full 255 bytes show up rarely.
    function automatic void build_request();
        byte_t atyp;
        int    alen;
        int    pick;
        frame.delete();
        frame.push_back(SOCKS_VERSION);
        pick = $urandom_range(0, 2);
        frame.push_back(pick == 0 ? CMD_TCP_OUT : (pick == 1 ? CMD_TCP_IN : CMD_UDP_ASSOC));
        frame.push_back(byte_t'($urandom));
        pick = $urandom_range(0, 2);
        atyp = pick == 0 ? ATYP_IPV4 : (pick == 1 ? ATYP_IPV6 : ATYP_DOMAIN);
        frame.push_back(atyp);
        if (atyp == ATYP_IPV4)
            alen = int'(LEN_IPV4);
        else if (atyp == ATYP_IPV6)
            alen = int'(LEN_IPV6);
        else
        begin
            if ($urandom_range(0, 59) == 0)
                alen = 255;
            else if ($urandom_range(0, 7) == 0)
                alen = 0;
            else
                alen = $urandom_range(1, 24);
            frame.push_back(byte_t'(alen));
        end
        repeat (alen) frame.push_back(byte_t'($urandom));
        frame.push_back(byte_t'($urandom));
        frame.push_back(byte_t'($urandom));
    endfunction

    initial
    begin
        int target;
        int flaw;
        int idx;

        rst_n               = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.restart   <= 1'b0;
        req_ch.data_byte <= '0;
        repeat (6) @(posedge clk);
        // Release reset away from the rising edge so no flop sees it mid-update.
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part.
        // First request right after reset, without restart: IPv4 outbound
        // request with extreme address and port bytes, then one byte past
        // the end, then one more to see the error stick.
        send_word(1'b0, SOCKS_VERSION);
        send_word(1'b0, CMD_TCP_OUT);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, ATYP_IPV4);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h80);
        send_word(1'b0, 8'h7F);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hA5);
        // Wrong version byte.
        send_word(1'b1, 8'h04);
        // Unknown command: still captured.
        send_word(1'b1, SOCKS_VERSION);
        send_word(1'b0, 8'h00);
        // Unknown address type: still captured.
        send_word(1'b1, SOCKS_VERSION);
        send_word(1'b0, CMD_UDP_ASSOC);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        // Empty domain name: the length byte leads straight to the port.
        send_word(1'b1, SOCKS_VERSION);
        send_word(1'b0, CMD_TCP_IN);
        send_word(1'b0, 8'h00);
        send_word(1'b0, ATYP_DOMAIN);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'h00);

        // Random part: mostly clean requests, the rest damaged or noise.
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            calm = ($urandom_range(0, 7) == 0);
            flaw = $urandom_range(0, 99);
            build_request();
            if (flaw < 94)
            begin
                if (flaw >= 70 && flaw < 78)
                begin
                    // Trailing bytes after a complete request.
                    repeat ($urandom_range(1, 3)) frame.push_back(byte_t'($urandom));
                end
                else if (flaw >= 78 && flaw < 86)
                begin
                    // Damage the version, command or address type byte.
                    idx = $urandom_range(0, 2);
                    idx = (idx == 2) ? 3 : idx;
                    frame[idx] = byte_t'($urandom);
                end
                else if (flaw >= 86)
                begin
                    // Cut the request short; the next one restarts mid-stream.
                    repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
                end
                send_frame();
            end
            else
            begin
                // Raw noise with random restart bits.
                repeat ($urandom_range(1, 6))
                    send_word(1'($urandom_range(0, 1)), byte_t'($urandom));
            end
        end

        // Drain: drop valid, let the checker register the last word, then
        // wait for every pending word to be compared.
        calm = 1'b0;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (in_flight == 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d request bytes (%0d framed requests); compared %0d result words,",
                 bytes_sent, frames_sent, compared);
        $display("%0d requests completed. Covered IPv4/IPv6/domain requests incl. empty and",
                 completed);
        $display("255-byte names, header errors, truncation, trailing bytes and noise.");
        if (mismatches == 0 && in_flight == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
